// File: rtl/kdfd_pkg.sv
// kdfd_pkg: shared types and constants of the kermit data field decoder
// no dependencies
package kdfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegRepeatEnable  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRepeatPrefix  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEightBitPrefix = 3'd2;
  localparam logic [CfgIdxW-1:0] RegControlPrefix = 3'd3;

  // reset values of the registers
  localparam logic [ByteW-1:0] RepeatPrefixRst   = 8'd126;
  localparam logic [ByteW-1:0] EightBitPrefixRst = 8'd78;
  localparam logic [ByteW-1:0] ControlPrefixRst  = 8'd35;

  // 'N' in the eight-bit prefix register turns that prefix off
  localparam logic [ByteW-1:0] EightBitOff = 8'h4E;

  // control quoting window and special character
  localparam logic [6:0] QuoteLow  = 7'o100;
  localparam logic [6:0] QuoteHigh = 7'o137;
  localparam logic [6:0] QuoteQmark = 7'h3F;
  localparam logic [ByteW-1:0] QuoteFlip = 8'h40;
  localparam logic [ByteW-1:0] HighBit   = 8'h80;
  localparam logic [ByteW-1:0] CountBias = 8'd32;

  typedef struct packed {
    logic             repeat_enable;
    logic [ByteW-1:0] repeat_prefix;
    logic [ByteW-1:0] eight_bit_prefix;
    logic [ByteW-1:0] control_prefix;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]  decoded_byte;
    logic [CountW-1:0] repeat_count;
    logic              end_of_packet;
    logic              truncated;
  } res_t;

endpackage

// File: rtl/kdfd_cfg.sv
// kdfd_cfg: configuration registers written through the plain write port
// depends on kdfd_pkg
module kdfd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kdfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [kdfd_pkg::ByteW-1:0]       cfg_data_i,
  output kdfd_pkg::cfg_t                   cfg_o
);

  kdfd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_enable    <= 1'b0;
      cfg_q.repeat_prefix    <= kdfd_pkg::RepeatPrefixRst;
      cfg_q.eight_bit_prefix <= kdfd_pkg::EightBitPrefixRst;
      cfg_q.control_prefix   <= kdfd_pkg::ControlPrefixRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kdfd_pkg::RegRepeatEnable:   cfg_q.repeat_enable    <= cfg_data_i[0];
        kdfd_pkg::RegRepeatPrefix:   cfg_q.repeat_prefix    <= cfg_data_i;
        kdfd_pkg::RegEightBitPrefix: cfg_q.eight_bit_prefix <= cfg_data_i;
        kdfd_pkg::RegControlPrefix:  cfg_q.control_prefix   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/kdfd_decode.sv
// kdfd_decode: prefix sequence state and the per-byte decode logic
// depends on kdfd_pkg
module kdfd_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kdfd_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [kdfd_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        packet_end_i,
  output logic                        emit_o,
  output kdfd_pkg::res_t              res_o
);

  localparam logic [2:0] PhFirst  = 3'd0;
  localparam logic [2:0] PhCount  = 3'd1;
  localparam logic [2:0] PhAftCnt = 3'd2;
  localparam logic [2:0] PhAft8   = 3'd3;
  localparam logic [2:0] PhQuoted = 3'd4;

  logic [2:0]                    phase_q, phase_d, ph;
  logic [kdfd_pkg::CountW-1:0]   count_q, count_d;
  logic                          hb_q, hb_d;
  logic                          done;
  logic [kdfd_pkg::ByteW-1:0]    ch;
  logic [6:0]                    low;

  assign low = data_byte_i[6:0];
  assign ph  = (phase_q > PhQuoted) ? PhFirst : phase_q;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    hb_d    = hb_q;
    done    = 1'b0;
    ch      = '0;
    res_o   = '0;
    case (ph)
      PhCount: begin
        count_d = (data_byte_i < kdfd_pkg::CountBias) ? '0
                                                      : data_byte_i - kdfd_pkg::CountBias;
        phase_d = PhAftCnt;
      end
      PhQuoted: begin
        ch = data_byte_i;
        if (data_byte_i != cfg_i.control_prefix &&
            ((low >= kdfd_pkg::QuoteLow && low <= kdfd_pkg::QuoteHigh) ||
             low == kdfd_pkg::QuoteQmark)) begin
          ch = data_byte_i ^ kdfd_pkg::QuoteFlip;
        end
        done = 1'b1;
      end
      default: begin
        if (ph == PhFirst && cfg_i.repeat_enable && data_byte_i == cfg_i.repeat_prefix) begin
          phase_d = PhCount;
        end else if (ph != PhAft8 && cfg_i.eight_bit_prefix != kdfd_pkg::EightBitOff &&
                     data_byte_i == cfg_i.eight_bit_prefix) begin
          hb_d    = 1'b1;
          phase_d = PhAft8;
        end else if (data_byte_i == cfg_i.control_prefix) begin
          phase_d = PhQuoted;
        end else begin
          ch   = data_byte_i;
          done = 1'b1;
        end
      end
    endcase

    if (done) begin
      res_o.decoded_byte  = hb_q ? (ch | kdfd_pkg::HighBit) : ch;
      res_o.repeat_count  = count_q;
      res_o.end_of_packet = packet_end_i;
      res_o.truncated     = 1'b0;
    end else if (packet_end_i) begin
      res_o.end_of_packet = 1'b1;
      res_o.truncated     = 1'b1;
    end

    // a finished sequence or end of packet starts over
    if (done || packet_end_i) begin
      phase_d = PhFirst;
      count_d = kdfd_pkg::CountW'(1);
      hb_d    = 1'b0;
    end
  end

  assign emit_o = done || packet_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      count_q <= kdfd_pkg::CountW'(1);
      hb_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      hb_q    <= hb_d;
    end
  end

endmodule

// File: rtl/kermit_data_field_decoder.sv
// kermit_data_field_decoder: top level with input word register and result register
// depends on kdfd_pkg, kdfd_cfg, kdfd_decode
//
// Decodes the data field of a Kermit packet one byte per word. Each input word
// is taken into an input register, decoded by a single pass of logic against
// the prefix state and the configuration, and its result (if any) lands in an
// output register. Throughput is one word per cycle while results are taken.
// A word that makes a result waits in the input register while the output
// register holds a result that is not taken, and the input stalls behind it.
// A word yields a result when it completes a prefix sequence or carries
// packet_end; prefix bytes alone yield nothing. Configuration writes must
// only happen while the block holds no word.
module kermit_data_field_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kdfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [kdfd_pkg::ByteW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kdfd_pkg::ByteW-1:0]       data_byte_i,
  input  logic                             packet_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kdfd_pkg::ByteW-1:0]       decoded_byte_o,
  output logic [kdfd_pkg::CountW-1:0]      repeat_count_o,
  output logic                             end_of_packet_o,
  output logic                             truncated_o
);

  kdfd_pkg::cfg_t              cfg;
  kdfd_pkg::res_t              res, res_q;
  logic                        emit, advance;
  logic                        in_valid_q, out_valid_q;
  logic [kdfd_pkg::ByteW-1:0]  in_byte_q;
  logic                        in_end_q;

  kdfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kdfd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .data_byte_i  (in_byte_q),
    .packet_end_i (in_end_q),
    .emit_o       (emit),
    .res_o        (res)
  );

  // word moves on unless its result finds the output register still full
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= packet_end_i;
    end
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_byte_o  = res_q.decoded_byte;
  assign repeat_count_o  = res_q.repeat_count;
  assign end_of_packet_o = res_q.end_of_packet;
  assign truncated_o     = res_q.truncated;

endmodule

// File: test/kermit_data_field_decoder_test.sv
// kermit_data_field_decoder_test: self-checking bench for the kermit data field decoder
// directed and random packets against an in-bench decoder model, random idling on both sides
// depends on kdfd_pkg and kermit_data_field_decoder
module kermit_data_field_decoder_test;
  import kdfd_pkg::*;

  localparam int SettleCycles = 6;
  localparam int StuckLimit = 1000;

  typedef enum logic [2:0] {
    PhFirst,
    PhCount,
    PhAfterCount,
    PhAfterEight,
    PhQuoted
  } phase_e;

  class kdfd_scoreboard;
    cfg_t cfg;
    phase_e phase;
    logic [CountW-1:0] held_count;
    logic high_pending;
    res_t expected_q[$];
    int errors;
    int checked;

    function new();
      cfg.repeat_enable = 1'b0;
      cfg.repeat_prefix = RepeatPrefixRst;
      cfg.eight_bit_prefix = EightBitPrefixRst;
      cfg.control_prefix = ControlPrefixRst;
      errors = 0;
      checked = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      phase = PhFirst;
      held_count = 1;
      high_pending = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        RegRepeatEnable: cfg.repeat_enable = val[0];
        RegRepeatPrefix: cfg.repeat_prefix = val;
        RegEightBitPrefix: cfg.eight_bit_prefix = val;
        RegControlPrefix: cfg.control_prefix = val;
        default: ;
      endcase
    endfunction

    // decode one accepted word and queue its result, if it makes one
    function void note_word(logic [ByteW-1:0] b, logic last);
      res_t want;
      logic [ByteW-1:0] ch;
      logic emit;
      emit = 1'b0;
      ch = b;
      case (phase)
        PhCount: begin
          held_count = (b < CountBias) ? '0 : b - CountBias;
          phase = PhAfterCount;
        end
        PhQuoted: begin
          if (b != cfg.control_prefix) begin
            if ((b[6:0] >= QuoteLow && b[6:0] <= QuoteHigh) || b[6:0] == QuoteQmark) begin
              ch = b ^ QuoteFlip;
            end
          end
          emit = 1'b1;
        end
        default: begin
          if (phase == PhFirst && cfg.repeat_enable && b == cfg.repeat_prefix) begin
            phase = PhCount;
          end else if (phase != PhAfterEight && cfg.eight_bit_prefix != EightBitOff
                       && b == cfg.eight_bit_prefix) begin
            high_pending = 1'b1;
            phase = PhAfterEight;
          end else if (b == cfg.control_prefix) begin
            phase = PhQuoted;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
      if (emit) begin
        want.decoded_byte = high_pending ? (ch | HighBit) : ch;
        want.repeat_count = held_count;
        want.end_of_packet = last;
        want.truncated = 1'b0;
        expected_q.push_back(want);
        clear_sequence();
      end else if (last) begin
        want.decoded_byte = '0;
        want.repeat_count = '0;
        want.end_of_packet = 1'b1;
        want.truncated = 1'b1;
        expected_q.push_back(want);
        clear_sequence();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none got byte %0h count %0d eop %b trunc %b",
                 $time, got.decoded_byte, got.repeat_count, got.end_of_packet, got.truncated);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("decoded_byte", want.decoded_byte, got.decoded_byte);
      compare_field("repeat_count", want.repeat_count, got.repeat_count);
      compare_field("end_of_packet", 8'(want.end_of_packet), 8'(got.end_of_packet));
      compare_field("truncated", 8'(want.truncated), 8'(got.truncated));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic packet_end_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [ByteW-1:0] decoded_byte_o;
  logic [CountW-1:0] repeat_count_o;
  logic end_of_packet_o;
  logic truncated_o;

  kdfd_scoreboard sb = new();
  logic [ByteW-1:0] field_q[$];
  int idle_pct = 0;
  int words_sent = 0;
  int settings = 0;
  int stuck_cycles = 0;

  kermit_data_field_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .packet_end_i   (packet_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .decoded_byte_o (decoded_byte_o),
    .repeat_count_o (repeat_count_o),
    .end_of_packet_o(end_of_packet_o),
    .truncated_o    (truncated_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // one well-formed prefix sequence with random content
  function automatic void add_sequence();
    logic [ByteW-1:0] b;
    if (sb.cfg.repeat_enable && $urandom_range(1) == 1) begin
      field_q.push_back(sb.cfg.repeat_prefix);
      if ($urandom_range(4) == 0) field_q.push_back(8'($urandom_range(31)));
      else field_q.push_back(8'($urandom_range(32, 255)));
    end
    if (sb.cfg.eight_bit_prefix != EightBitOff && $urandom_range(2) == 0) begin
      field_q.push_back(sb.cfg.eight_bit_prefix);
    end
    if ($urandom_range(4) < 2) begin
      field_q.push_back(sb.cfg.control_prefix);
      case ($urandom_range(3))
        0: b = {1'($urandom), 7'($urandom_range(QuoteLow, QuoteHigh))};
        1: b = {1'($urandom), QuoteQmark};
        2: b = sb.cfg.control_prefix;
        default: b = 8'($urandom);
      endcase
      field_q.push_back(b);
    end else begin
      field_q.push_back(8'($urandom));
    end
  endfunction

  task automatic send_word(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    packet_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(b, last);
    words_sent++;
  endtask

  task automatic send_field();
    foreach (field_q[i]) send_word(field_q[i], i == field_q.size() - 1);
    field_q.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // all four registers, then a write to an unused index
  task automatic program_regs(input logic en, input logic [ByteW-1:0] rep,
                              input logic [ByteW-1:0] eight, input logic [ByteW-1:0] ctl);
    logic [CfgIdxW-1:0] idx[5];
    logic [ByteW-1:0] val[5];
    idx[0] = RegRepeatEnable;
    idx[1] = RegRepeatPrefix;
    idx[2] = RegEightBitPrefix;
    idx[3] = RegControlPrefix;
    idx[4] = CfgIdxW'($urandom_range(int'(RegControlPrefix) + 1, (1 << CfgIdxW) - 1));
    val[0] = {7'($urandom), en};
    val[1] = rep;
    val[2] = eight;
    val[3] = ctl;
    val[4] = 8'($urandom);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic send_packet();
    if ($urandom_range(9) == 0) begin
      // noise: prefix characters and random bytes in any order
      repeat ($urandom_range(1, 16)) begin
        case ($urandom_range(3))
          0: field_q.push_back(sb.cfg.repeat_prefix);
          1: field_q.push_back(sb.cfg.eight_bit_prefix);
          2: field_q.push_back(sb.cfg.control_prefix);
          default: field_q.push_back(8'($urandom));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 10)) add_sequence();
      if ($urandom_range(6) == 0) begin
        // cut the packet short, often inside a sequence
        repeat ($urandom_range(0, field_q.size() - 1)) void'(field_q.pop_back());
      end
    end
    send_field();
  endtask

  task automatic run_words(input int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(99) == 0) wait_drained();
      send_packet();
    end
    wait_drained();
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word({decoded_byte_o, repeat_count_o, end_of_packet_o, truncated_o});
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StuckLimit);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    packet_end_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: quoting window, doubled quote, 'N' and '~' as plain data
    idle_pct = 20;
    field_q = '{"A", 8'h00, "#", "A", "#", "#", "#", "?", "#", 8'hC1, "N", "~", 8'hFF};
    send_field();
    field_q = '{"#"};
    send_field();
    wait_drained();

    // repeat count, eight-bit prefix, count below bias, doubled eight-bit prefix
    program_regs(1'b1, "~", "&", "#");
    field_q = '{"~", 8'h25, "&", "#", 8'h20, "~", 8'h10, "q", "&", "&", "~"};
    send_field();
    wait_drained();

    idle_pct = 30;
    run_words(250);
    idle_pct = 0;
    program_regs(1'b1, 8'hFF, 8'h00, 8'hFF);
    run_words(200);
    idle_pct = 50;
    program_regs(1'b0, 8'h00, EightBitOff, 8'h00);
    run_words(200);
    idle_pct = 25;
    program_regs(1'b1, "A", "#", "#");
    run_words(200);
    idle_pct = 35;
    program_regs(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_words(250);

    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d words sent, %0d results checked, %0d register settings",
             words_sent, sb.checked, settings);
    $display("covered repeat counts, eight-bit and control quoting, cut-off packets, noise");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: kermit_data_field_decoder.f
rtl/kdfd_pkg.sv
rtl/kdfd_cfg.sv
rtl/kdfd_decode.sv
rtl/kermit_data_field_decoder.sv
test/kermit_data_field_decoder_test.sv
